### src/ptc_pkg.sv
// Package for the point-turn controller: codes, field widths, constant tables and shared types.
package ptc_pkg;

	// Stream and configuration port widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 9;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SLOWEST = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FASTEST = 1'd1;

	// Request kinds carried on tuser
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Phase codes reported with each result
	localparam logic [1:0] PHASE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_TURN = 2'd1;
	localparam logic [1:0] PHASE_WAIT = 2'd2;
	localparam logic [1:0] PHASE_DONE = 2'd3;

	// Geometry and control constants, tenths of a degree unless noted; ANGLE_LIMIT is in whole degrees
	localparam int BAND_COUNT = 6;
	localparam logic [9:0]  ANGLE_LIMIT   = 10'd360;
	localparam logic [15:0] TURN_OFFSET   = 16'd3600;
	localparam logic [11:0] WRAP_LOW      = 12'd50;
	localparam logic [11:0] WRAP_HIGH     = 12'd3550;
	localparam logic [15:0] OVERSHOOT_MAX = 16'd1800;
	localparam logic [16:0] SINE_KNEE     = 17'd900;
	localparam logic [1:0]  SETTLE_RELOAD = 2'd2;

	// Sine interpolation: 5-degree steps, reciprocals of the step width
	localparam logic [9:0]  SINE_STEP    = 10'd50;
	localparam logic [14:0] SINE_FULL    = 15'd32767;
	localparam logic [10:0] RECIP50_Q16  = 11'd1311;
	localparam logic [18:0] RECIP50_Q24  = 19'd335545;
	localparam logic [24:0] ROUND_HALF   = 25'd16384;

	// Speed band thresholds on the mean wheel speed, mm/s
	localparam logic [11:0] BAND_LIMIT [0:BAND_COUNT-2] = '{
		12'd60, 12'd120, 12'd180, 12'd250, 12'd280
	};

	// Control that travels with an item down the drive pipeline
	typedef struct packed {
		logic       go;
		logic [1:0] phase;
		logic       cw;
		logic [8:0] base;
		logic [8:0] span;
	} drive_ctl_t;

	// Q0.15 sine at 5-degree steps from 0 to 90 degrees
	function automatic logic [14:0] sine_q15(input logic [4:0] idx);
		logic [14:0] v;
		case (idx)
			5'd0:    v = 15'd0;
			5'd1:    v = 15'd2856;
			5'd2:    v = 15'd5690;
			5'd3:    v = 15'd8481;
			5'd4:    v = 15'd11207;
			5'd5:    v = 15'd13848;
			5'd6:    v = 15'd16384;
			5'd7:    v = 15'd18795;
			5'd8:    v = 15'd21063;
			5'd9:    v = 15'd23170;
			5'd10:   v = 15'd25102;
			5'd11:   v = 15'd26842;
			5'd12:   v = 15'd28378;
			5'd13:   v = 15'd29698;
			5'd14:   v = 15'd30792;
			5'd15:   v = 15'd31652;
			5'd16:   v = 15'd32270;
			5'd17:   v = 15'd32643;
			5'd18:   v = 15'd32767;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// Overshoot entries after reset, one per speed band
	function automatic logic [15:0] overshoot_init(input logic [2:0] band);
		logic [15:0] v;
		case (band)
			3'd0:    v = 16'd30;
			3'd1:    v = 16'd110;
			3'd2:    v = 16'd220;
			3'd3:    v = 16'd380;
			3'd4:    v = 16'd550;
			3'd5:    v = 16'd800;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

### src/point_turn_controller.sv
// Point-turn controller: turn state, overshoot learning and sine-profiled wheel drive pipeline.
//
// Usage
//   Input stream (s_*): one request per item. s_tuser selects start (0) or control tick (1).
//   A start loads the target heading and the speed limits; a tick reports the heading and
//   measured wheel speeds and returns the commanded drives.
//   Output stream (m_*): exactly one result per request, in request order, carrying the
//   left and right drive commands and the turn phase.
//   Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_addr (0 slowest
//   speed, 1 fastest speed); write only while no request is in flight.
// Timing
//   A request is held in the input register, then passes the turn-state stage, three sine
//   and scaling stages and the result register before the result is valid on m_*.
//   Throughput is one request per cycle unless a low m_tready stalls the output; the turn
//   state is updated in a single stage, so a tick immediately following another sees its state.
// Reset and stalls
//   arst_n clears the pipeline, the turn state and the overshoot table to its initial
//   entries, and the speed registers to 16 and 150 mm/s.
//   Each stage holds while the next one is full and blocked, so empty stages keep taking
//   requests while a result waits on a low m_tready; s_tready drops only when all stages fill.
module point_turn_controller
	import ptc_pkg::*;
#(
	parameter int SPEED_FLOOR   = 16,
	parameter int SPEED_CEILING = 300
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [9:0] turn_angle, [21:10] heading, [32:22] left_wheel_speed,
	// [43:33] right_wheel_speed, [47:44] zero
	input  logic [IN_TDATA_W-1:0] s_tdata,
	// [0] command
	input  logic                  s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [9:0] left_drive, [19:10] right_drive, [21:20] phase, [23:22] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [8:0] FLOOR_W = 9'(SPEED_FLOOR);
	localparam logic [8:0] CEIL_W  = 9'(SPEED_CEILING);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_TURN   = 2'd1,
		MODE_WAIT   = 2'd2,
		MODE_FINISH = 2'd3
	} mode_t;

	// Configuration registers
	logic [8:0] slowest_q;
	logic [8:0] fastest_q;

	// Turn state
	mode_t       mode_q, mode_d;
	logic [15:0] target_q, target_d;
	logic [11:0] prev_q, prev_d;
	logic        cw_q, cw_d;
	logic [8:0]  base_q, base_d;
	logic [8:0]  span_q, span_d;
	logic [1:0]  settle_q, settle_d;
	logic [2:0]  band_q, band_d;
	logic [15:0] tbl_q [0:BAND_COUNT-1];
	logic [15:0] tbl_wr_data;
	logic        tbl_wr_en;

	// Pipeline valid and ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;
	logic step_s1;

	// Stage payloads
	logic              cmd_s1;
	logic signed [9:0] angle_s1;
	logic [11:0]       heading_s1;
	logic signed [10:0] left_s1, right_s1;

	drive_ctl_t  ctl_d, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [15:0] diff_d, diff_s2;
	logic        sat_lo_s3, sat_hi_s3, sat_lo_s4, sat_hi_s4;
	logic [14:0] lo_s3, lo_s4;
	logic [11:0] delta_s3;
	logic [5:0]  frac_s3;
	logic [17:0] prod_s4;
	logic [14:0] sine_s5;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// Combinational intermediates of the turn-state stage
	logic signed [9:0]  deg;
	logic signed [13:0] deg_x10;
	logic [8:0]  hi_lim, lo_lim;
	logic [15:0] tgt;
	logic [10:0] abs_l, abs_r;
	logic [11:0] speed_avg;
	logic [2:0]  band_now, rd_band;
	logic [15:0] entry_raw, entry;
	logic signed [17:0] resid;
	logic [17:0] adapt_sum;

	// Intermediates of the sine and scaling stages
	logic signed [16:0] knee_d;
	logic [9:0]  knee_n;
	logic [20:0] idx_prod;
	logic [4:0]  sine_idx;
	logic [9:0]  idx_x50;
	logic [14:0] sine_lo, sine_hi;
	logic [36:0] q_prod;
	logic [24:0] scale_prod;
	logic [9:0]  speed;
	logic [9:0]  drive_r;

	// Handshake chain: a stage loads when it is empty or its content moves on
	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s5   = !v_s5 || rdy_out;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign step_s1  = v_s1 && rdy_s2;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slowest_q <= 9'd16;
			fastest_q <= 9'd150;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_SLOWEST: slowest_q <= cfg_wdata;
				REG_FASTEST: fastest_q <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// Capture the request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			cmd_s1     <= s_tuser;
			angle_s1   <= s_tdata[9:0];
			heading_s1 <= s_tdata[21:10];
			left_s1    <= s_tdata[32:22];
			right_s1   <= s_tdata[43:33];
		end
	end

	// Turn-state stage: start handling, wraparound, band choice, settle and learning
	always_comb begin
		mode_d      = mode_q;
		target_d    = target_q;
		prev_d      = prev_q;
		cw_d        = cw_q;
		base_d      = base_q;
		span_d      = span_q;
		settle_d    = settle_q;
		band_d      = band_q;
		tbl_wr_en   = 1'b0;
		tbl_wr_data = 16'd0;
		diff_d      = 16'd0;
		ctl_d       = '{go: 1'b0, phase: PHASE_IDLE, cw: cw_q, base: base_q, span: span_q};

		// Fold the angle once into range and scale to tenths
		deg = angle_s1;
		if (angle_s1 > $signed(ANGLE_LIMIT)) begin
			deg = angle_s1 - $signed(ANGLE_LIMIT);
		end else if (angle_s1 < -$signed(ANGLE_LIMIT)) begin
			deg = angle_s1 + $signed(ANGLE_LIMIT);
		end
		deg_x10 = ({{4{deg[9]}}, deg} <<< 3) + ({{4{deg[9]}}, deg} <<< 1);

		// Clamp the speed limits
		hi_lim = (fastest_q >= CEIL_W) ? CEIL_W : fastest_q;
		if (hi_lim <= FLOOR_W) begin
			hi_lim = FLOOR_W;
		end
		lo_lim = (slowest_q > hi_lim) ? hi_lim : slowest_q;
		if (lo_lim < FLOOR_W) begin
			lo_lim = FLOOR_W;
		end

		// Follow heading wraparound
		tgt = target_q;
		if (cw_q) begin
			if (heading_s1 > prev_q && prev_q < WRAP_LOW) begin
				tgt = target_q + TURN_OFFSET;
			end
			diff_d = {4'd0, heading_s1} - tgt + TURN_OFFSET;
		end else begin
			if (heading_s1 < prev_q && prev_q > WRAP_HIGH) begin
				tgt = target_q - TURN_OFFSET;
			end
			diff_d = tgt - {4'd0, heading_s1} - TURN_OFFSET;
		end

		// Speed band from the mean wheel speed
		abs_l     = left_s1[10] ? 11'(-left_s1) : 11'(left_s1);
		abs_r     = right_s1[10] ? 11'(-right_s1) : 11'(right_s1);
		speed_avg = 12'(({1'b0, abs_l} + {1'b0, abs_r}) >> 1);
		band_now  = 3'd0;
		for (int k = 0; k < BAND_COUNT - 1; k++) begin
			band_now = band_now + 3'(speed_avg >= BAND_LIMIT[k]);
		end

		// One read of the overshoot table per item
		rd_band   = (mode_q == MODE_FINISH) ? band_q : band_now;
		entry_raw = tbl_q[rd_band];
		entry     = (entry_raw > OVERSHOOT_MAX) ? 16'd0 : entry_raw;

		// Residual for learning, floored at zero
		resid = $signed({2'b00, entry_raw}) - $signed({{2{diff_d[15]}}, diff_d});
		if (resid < 0) begin
			resid = 18'sd0;
		end
		adapt_sum = {2'b00, entry_raw} + 18'(resid);

		if (cmd_s1 == CMD_START) begin
			base_d     = lo_lim;
			span_d     = hi_lim - lo_lim;
			target_d   = 16'(heading_s1) + {{2{deg_x10[13]}}, deg_x10} + TURN_OFFSET;
			prev_d     = heading_s1;
			cw_d       = deg[9];
			if (deg != 10'sd0) begin
				mode_d      = MODE_TURN;
				settle_d    = SETTLE_RELOAD;
				ctl_d.phase = PHASE_TURN;
			end else begin
				mode_d = MODE_IDLE;
			end
		end else if (mode_q != MODE_IDLE) begin
			target_d = tgt;
			prev_d   = heading_s1;
			unique case (mode_q)
				MODE_TURN: begin
					band_d = band_now;
					if (entry_raw > OVERSHOOT_MAX) begin
						tbl_wr_en   = 1'b1;
						tbl_wr_data = 16'd0;
					end
					if ($signed({diff_d[15], diff_d}) > $signed({1'b0, entry})) begin
						ctl_d.go    = 1'b1;
						ctl_d.phase = PHASE_TURN;
					end else begin
						mode_d      = MODE_WAIT;
						ctl_d.phase = PHASE_WAIT;
					end
				end
				MODE_WAIT: begin
					if (left_s1 == 11'sd0 && right_s1 == 11'sd0) begin
						if (settle_q == 2'd0) begin
							mode_d = MODE_FINISH;
						end
						settle_d = settle_q - 2'd1;
					end else begin
						settle_d = SETTLE_RELOAD;
					end
					ctl_d.phase = PHASE_WAIT;
				end
				MODE_FINISH: begin
					tbl_wr_en   = 1'b1;
					tbl_wr_data = adapt_sum[16:1];
					mode_d      = MODE_IDLE;
					ctl_d.phase = PHASE_DONE;
				end
				default: ;
			endcase
		end
	end

	// Hold the turn state and advance it as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			target_q <= 16'd0;
			prev_q   <= 12'd0;
			cw_q     <= 1'b0;
			base_q   <= 9'd0;
			span_q   <= 9'd0;
			settle_q <= SETTLE_RELOAD;
			band_q   <= 3'd0;
			for (int b = 0; b < BAND_COUNT; b++) begin
				tbl_q[b] <= overshoot_init(3'(b));
			end
		end else if (step_s1) begin
			mode_q   <= mode_d;
			target_q <= target_d;
			prev_q   <= prev_d;
			cw_q     <= cw_d;
			base_q   <= base_d;
			span_q   <= span_d;
			settle_q <= settle_d;
			band_q   <= band_d;
			if (tbl_wr_en) begin
				tbl_q[rd_band] <= tbl_wr_data;
			end
		end
	end

	// Sine index and interpolation fraction from the angle beyond the knee
	always_comb begin
		knee_d   = $signed({diff_s2[15], diff_s2}) - $signed(SINE_KNEE);
		knee_n   = knee_d[9:0];
		idx_prod = 21'(knee_n) * 21'(RECIP50_Q16);
		sine_idx = idx_prod[20:16];
		idx_x50  = 10'({sine_idx, 5'd0} + {sine_idx, 4'd0} + {sine_idx, 1'd0});
		sine_lo  = sine_q15(sine_idx);
		sine_hi  = sine_q15(sine_idx + 5'd1);
	end

	// Divide the interpolation product by the step width
	assign q_prod = 37'(prod_s4) * 37'(RECIP50_Q24);

	// Scale the sine onto the speed span and set the drive direction
	always_comb begin
		scale_prod = 25'(sine_s5) * 25'(ctl_s5.span) + ROUND_HALF;
		speed      = 10'(ctl_s5.base) + scale_prod[24:15];
		drive_r    = 10'd0;
		if (ctl_s5.go) begin
			drive_r = ctl_s5.cw ? 10'(-speed) : speed;
		end
	end

	// Advance valid bits down the drive pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_out) begin
				out_valid_q <= v_s5;
			end
		end
	end

	// Advance payloads down the drive pipeline
	always_ff @(posedge clk) begin
		if (step_s1) begin
			ctl_s2  <= ctl_d;
			diff_s2 <= diff_d;
		end
		if (rdy_s3 && v_s2) begin
			ctl_s3    <= ctl_s2;
			sat_lo_s3 <= knee_d[16] || (knee_d == 17'sd0);
			sat_hi_s3 <= knee_d >= $signed(SINE_KNEE);
			lo_s3     <= sine_lo;
			delta_s3  <= 12'(sine_hi - sine_lo);
			frac_s3   <= 6'(knee_n - idx_x50);
		end
		if (rdy_s4 && v_s3) begin
			ctl_s4    <= ctl_s3;
			sat_lo_s4 <= sat_lo_s3;
			sat_hi_s4 <= sat_hi_s3;
			lo_s4     <= lo_s3;
			prod_s4   <= 18'(delta_s3) * 18'(frac_s3);
		end
		if (rdy_s5 && v_s4) begin
			ctl_s5 <= ctl_s4;
			if (sat_lo_s4) begin
				sine_s5 <= 15'd0;
			end else if (sat_hi_s4) begin
				sine_s5 <= SINE_FULL;
			end else begin
				sine_s5 <= lo_s4 + 15'(q_prod[35:24]);
			end
		end
		if (rdy_out && v_s5) begin
			out_data_q <= {2'b00, ctl_s5.phase, drive_r, 10'(-drive_r)};
		end
	end

endmodule

### src/ptc_checker.sv
// Port-level assertions for the point-turn controller, bound to its top level.
module ptc_checker
	import ptc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Drives are zero outside the turning phase
	a_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21:20] != PHASE_TURN |-> m_tdata[19:0] == 20'd0)
		else $error("nonzero drive outside the turning phase");

	// Wheels are always driven in opposition
	a_opposed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] + m_tdata[19:10]) == 10'd0)
		else $error("left and right drives not opposed");

	// Leaving reset, the pipeline is empty and takes requests
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid && s_tready)
		else $error("pipeline not empty after reset");

endmodule

bind point_turn_controller ptc_checker u_ptc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
